// ===== hdl/irn_pkg.sv =====
// ----------------------------------------------------------------------------
// irn_pkg
// Types, character codes and digit tables shared by the Roman numeral
// converter.
// ----------------------------------------------------------------------------
package irn_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 7;
    localparam int DIGIT_W  = 4;
    localparam int DECADES  = 4;
    localparam int QDEPTH   = 2;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    // Reciprocal constants for division of a bounded value by a constant.
    localparam logic [12:0] RECIP_1000 = 13'd4195;
    localparam logic [5:0]  RECIP_100  = 6'd41;
    localparam logic [7:0]  RECIP_10   = 8'd205;

    localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4D;
    localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;

    typedef enum logic [1:0] {
        DEC_THOUSANDS = 2'd0,
        DEC_HUNDREDS  = 2'd1,
        DEC_TENS      = 2'd2,
        DEC_UNITS     = 2'd3
    } decade_t;

    typedef enum logic [1:0] {
        POS_ONE  = 2'd0,
        POS_FIVE = 2'd1,
        POS_TEN  = 2'd2,
        POS_NONE = 2'd3
    } glyph_pos_t;

    typedef struct packed {
        logic                             err;
        logic [DECADES-1:0][DIGIT_W-1:0]  digits;
    } item_t;

    function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] dig);
        logic [2:0] len;
        unique case (dig)
            4'd1, 4'd5:       len = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             len = 3'd2;
            4'd3, 4'd7:       len = 3'd3;
            4'd8:             len = 3'd4;
            default:          len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic glyph_pos_t digit_pos(input logic [DIGIT_W-1:0] dig,
                                             input logic [1:0]         idx);
        glyph_pos_t pos;
        pos = POS_ONE;
        if (dig == 4'd4 && idx == 2'd1)
            pos = POS_FIVE;
        else if (dig >= 4'd5 && dig <= 4'd8 && idx == 2'd0)
            pos = POS_FIVE;
        else if (dig == 4'd9 && idx == 2'd1)
            pos = POS_TEN;
        return pos;
    endfunction

    function automatic logic [SYMBOL_W-1:0] glyph(input decade_t    dec,
                                                  input glyph_pos_t pos);
        logic [SYMBOL_W-1:0] ch;
        unique case (dec)
            DEC_THOUSANDS: ch = CH_M;
            DEC_HUNDREDS:  ch = (pos == POS_FIVE) ? CH_D : (pos == POS_TEN) ? CH_M : CH_C;
            DEC_TENS:      ch = (pos == POS_FIVE) ? CH_L : (pos == POS_TEN) ? CH_C : CH_X;
            DEC_UNITS:     ch = (pos == POS_FIVE) ? CH_V : (pos == POS_TEN) ? CH_X : CH_I;
            default:       ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/irn_if.sv =====
// ----------------------------------------------------------------------------
// irn_if
// Valid/ready channels of the Roman numeral converter: one for the binary
// values and one for the characters.
// ----------------------------------------------------------------------------
interface irn_value_if import irn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface irn_char_if import irn_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                out_of_range;

    modport source (output valid, output symbol, output last, output out_of_range,
                    input ready);
    modport sink   (input valid, input symbol, input last, input out_of_range,
                    output ready);
endinterface

// ===== hdl/irn_front.sv =====
// ----------------------------------------------------------------------------
// irn_front
// Accepts binary values, checks the range and splits each value into decimal
// digits over two register stages.
// ----------------------------------------------------------------------------
module irn_front import irn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    irn_value_if.sink   numbers,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_err_reg, s1_err_next;
    logic [1:0]  s1_thou_reg, s1_thou_next;
    logic [9:0]  s1_rem_reg, s1_rem_next;

    logic        s2_valid_reg, s2_valid_next;
    logic        s2_err_reg, s2_err_next;
    logic [1:0]  s2_thou_reg, s2_thou_next;
    logic [3:0]  s2_hund_reg, s2_hund_next;
    logic [6:0]  s2_rem_reg, s2_rem_next;

    logic        s1_adv, s2_adv;
    logic [24:0] prod1;
    logic [2:0]  quo1;
    logic [11:0] rem1;
    logic [15:0] prod2;
    logic [3:0]  quo2;
    logic [9:0]  rem2;
    logic [14:0] prod3;
    logic [3:0]  quo3;
    logic [6:0]  rem3;

    assign s2_adv        = !s2_valid_reg || q_ready;
    assign s1_adv        = !s1_valid_reg || s2_adv;
    assign numbers.ready = s1_adv;

    always_comb
    begin
        prod1         = 25'(numbers.value) * 25'(RECIP_1000);
        quo1          = prod1[24:22];
        rem1          = numbers.value - 12'(13'(quo1) * 13'd1000);
        s1_valid_next = s1_adv ? numbers.valid : s1_valid_reg;
        s1_err_next   = (numbers.value == '0) || (numbers.value > MAX_VALUE);
        s1_thou_next  = quo1[1:0];
        s1_rem_next   = rem1[9:0];

        prod2         = 16'(s1_rem_reg) * 16'(RECIP_100);
        quo2          = prod2[15:12];
        rem2          = s1_rem_reg - 10'(11'(quo2) * 11'd100);
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
        s2_err_next   = s1_err_reg;
        s2_thou_next  = s1_thou_reg;
        s2_hund_next  = quo2;
        s2_rem_next   = rem2[6:0];

        prod3         = 15'(s2_rem_reg) * 15'(RECIP_10);
        quo3          = prod3[14:11];
        rem3          = s2_rem_reg - (7'(quo3) * 7'd10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_err_reg  <= s1_err_next;
            s1_thou_reg <= s1_thou_next;
            s1_rem_reg  <= s1_rem_next;
        end
        if (s2_adv)
        begin
            s2_err_reg  <= s2_err_next;
            s2_thou_reg <= s2_thou_next;
            s2_hund_reg <= s2_hund_next;
            s2_rem_reg  <= s2_rem_next;
        end
    end

    always_comb
    begin
        q_valid = s2_valid_reg;
        q_item.err = s2_err_reg;
        if (s2_err_reg)
            q_item.digits = '0;
        else
        begin
            q_item.digits[DEC_THOUSANDS] = {2'b00, s2_thou_reg};
            q_item.digits[DEC_HUNDREDS]  = s2_hund_reg;
            q_item.digits[DEC_TENS]      = quo3;
            q_item.digits[DEC_UNITS]     = rem3[3:0];
        end
    end

endmodule

// ===== hdl/irn_queue.sv =====
// ----------------------------------------------------------------------------
// irn_queue
// Short queue of digit sets between the front and the character sequencer.
// ----------------------------------------------------------------------------
module irn_queue import irn_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    item_t            entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign push_ready = (count_reg != (PTR_W+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hdl/irn_back.sv =====
// ----------------------------------------------------------------------------
// irn_back
// Character sequencer: walks the digits of one numeral and emits one Roman
// character per cycle, while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module irn_back import irn_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    irn_char_if.source chars
);

    logic                cur_valid_reg, cur_valid_next;
    item_t               cur_item_reg, cur_item_next;
    logic [1:0]          idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0] out_symbol_reg, out_symbol_next;
    logic                out_last_reg, out_last_next;
    logic                out_err_reg, out_err_next;

    logic [DECADES-1:0]  nz;
    decade_t             dec;
    logic [DIGIT_W-1:0]  dig;
    logic [2:0]          len;
    logic                digit_end;
    logic                any_after;
    logic                last_char;
    logic                emit;
    logic [SYMBOL_W-1:0] sym;

    always_comb
    begin
        for (int k = 0; k < DECADES; k++)
            nz[k] = (cur_item_reg.digits[k] != '0);

        priority if (nz[DEC_THOUSANDS]) dec = DEC_THOUSANDS;
        else if (nz[DEC_HUNDREDS])      dec = DEC_HUNDREDS;
        else if (nz[DEC_TENS])          dec = DEC_TENS;
        else                            dec = DEC_UNITS;

        unique case (dec)
            DEC_THOUSANDS: any_after = nz[DEC_HUNDREDS] || nz[DEC_TENS] || nz[DEC_UNITS];
            DEC_HUNDREDS:  any_after = nz[DEC_TENS] || nz[DEC_UNITS];
            DEC_TENS:      any_after = nz[DEC_UNITS];
            default:       any_after = 1'b0;
        endcase

        dig       = cur_item_reg.digits[dec];
        len       = digit_len(dig);
        digit_end = (idx_reg == 2'(len - 3'd1));
        last_char = cur_item_reg.err || (digit_end && !any_after);
        sym       = cur_item_reg.err ? CH_NONE : glyph(dec, digit_pos(dig, idx_reg));
        emit      = cur_valid_reg && (!out_valid_reg || chars.ready);
        q_ready   = !cur_valid_reg || (emit && last_char);
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_item_next  = cur_item_reg;
        idx_next       = idx_reg;

        if (emit)
        begin
            if (last_char)
                cur_valid_next = 1'b0;
            else if (digit_end)
            begin
                cur_item_next.digits[dec] = '0;
                idx_next = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end

        if (q_valid && q_ready)
        begin
            cur_valid_next = 1'b1;
            cur_item_next  = q_item;
            idx_next       = 2'd0;
        end

        out_valid_next  = emit ? 1'b1 : (chars.ready ? 1'b0 : out_valid_reg);
        out_symbol_next = emit ? sym : out_symbol_reg;
        out_last_next   = emit ? last_char : out_last_reg;
        out_err_next    = emit ? cur_item_reg.err : out_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_item_reg   <= cur_item_next;
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
        out_err_reg    <= out_err_next;
    end

    assign chars.valid        = out_valid_reg;
    assign chars.symbol       = out_symbol_reg;
    assign chars.last         = out_last_reg;
    assign chars.out_of_range = out_err_reg;

endmodule

// ===== hdl/integer_to_roman_numeral.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a 12-bit binary integer into its Roman numeral, one ASCII
// character per output transaction.
// ----------------------------------------------------------------------------
// Each value from 1 to 3999 yields one transaction per character, most
// significant first, with last set on the final one; any other value yields a
// single transaction with out_of_range and last set and a zero symbol. The
// character sequencer emits one character per cycle while the output is not
// stalled; a numeral has 1 to 15 characters (the longest being 3888), and
// consecutive numerals follow without gaps. The first character passes
// through the first and second digit-split stages, the queue, the sequencer's
// digit register and the output register. The input is taken while earlier
// numerals are still being sent, until the two-entry queue and the split
// stages fill.
module integer_to_roman_numeral import irn_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    irn_value_if.sink  numbers,
    irn_char_if.source chars
);

    logic  fq_valid, fq_ready;
    item_t fq_item;
    logic  qb_valid, qb_ready;
    item_t qb_item;

    irn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .numbers (numbers),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    irn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    irn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_item  (qb_item),
        .chars   (chars)
    );

endmodule

// ===== hdl/irn_checker.sv =====
// ----------------------------------------------------------------------------
// irn_checker
// Port-level checks of the Roman numeral converter, bound to the top level.
// ----------------------------------------------------------------------------
module irn_checker import irn_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SYMBOL_W-1:0] out_symbol,
    input logic                out_last,
    input logic                out_err
);

    logic [3:0] pending_reg, pending_next;
    logic       in_take, out_done;

    assign in_take  = in_valid && in_ready;
    assign out_done = out_valid && out_ready && out_last;
    assign pending_next = pending_reg + 4'(in_take) - 4'(out_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // An error transaction stands alone and carries no character.
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> out_last && out_symbol == CH_NONE)
        else $error("out_of_range transaction is not a lone zero symbol");

    a_symbol_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_err |-> out_symbol == CH_M || out_symbol == CH_D ||
            out_symbol == CH_C || out_symbol == CH_L || out_symbol == CH_X ||
            out_symbol == CH_V || out_symbol == CH_I)
        else $error("symbol is not a Roman character");

    // Every character belongs to a value that has been taken in.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("output transaction without an outstanding input");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
            $stable(out_last) && $stable(out_err))
        else $error("stalled output transaction changed");

endmodule

bind integer_to_roman_numeral irn_checker u_irn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (numbers.valid),
    .in_ready   (numbers.ready),
    .out_valid  (chars.valid),
    .out_ready  (chars.ready),
    .out_symbol (chars.symbol),
    .out_last   (chars.last),
    .out_err    (chars.out_of_range)
);
